@@ design/tfn_pkg.sv @@
// tfn_pkg: types, widths and helpers shared by the triangle face normal pipeline.
// Depends on nothing; every other design file imports it.
package tfn_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int TB_W       = $clog2(MAG_W);
   localparam int NORM_TOP   = 29;
   localparam int SM_W       = NORM_TOP + 1;
   localparam int SH_W       = $clog2(SM_W);
   localparam int SQ_W       = 2 * SM_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ONE_SHIFT  = 14;
   localparam int Q_W        = ONE_SHIFT + 1;
   localparam int NUM_W      = SM_W + ONE_SHIFT + 1;
   localparam int DREM_W     = ROOT_W + 1;
   localparam int OUT_W      = 16;
   localparam int THR_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [Q_W-1:0]   ONE_Q14            = Q_W'(1) << ONE_SHIFT;
   localparam logic [THR_W-1:0] ZERO_THRESHOLD_RST = THR_W'(1);
   localparam logic             CSR_ZERO_THRESHOLD = 1'b0;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type az;
      coord_type bx;
      coord_type by_coord;
      coord_type bz;
      coord_type cx;
      coord_type cy;
      coord_type cz;
      logic      last_triangle;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic                    degenerate;
      logic                    last;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
      logic       last;
   } side_type;

   typedef logic [2:0][MAG_W-1:0] mag_vec_type;
   typedef logic [2:0][SM_W-1:0]  sm_vec_type;
   typedef logic [2:0][Q_W-1:0]   q_vec_type;

   function automatic logic [TB_W-1:0] top_bit(input logic [MAG_W-1:0] v);
      logic [TB_W-1:0] tb;
      tb = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            tb = TB_W'(i);
         end
      end
      return tb;
   endfunction

endpackage

@@ design/tfn_cross.sv @@
// tfn_cross: edge differences, cross product, magnitude and zero threshold.
// Four register stages; depends on tfn_pkg.
module tfn_cross
   import tfn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  req_word_type       in_word,
   input  logic [THR_W-1:0]   zero_threshold,
   output logic               out_valid,
   output mag_vec_type        out_mag,
   output side_type           out_side
);

   logic [3:0]                 vld_ff;
   logic [2:0]                 last_ff;
   logic signed [DIFF_W-1:0]   d_in  [6];
   logic signed [DIFF_W-1:0]   d_ff  [6];
   logic signed [PROD_W-1:0]   p_in  [6];
   logic signed [PROD_W-1:0]   p_ff  [6];
   logic signed [CROSS_W-1:0]  c_in  [3];
   logic signed [CROSS_W-1:0]  c_ff  [3];
   mag_vec_type                mag_in;
   mag_vec_type                mag_ff;
   logic [2:0]                 neg_in;
   logic [2:0]                 neg_ff;
   logic                       last4_ff;

   always_comb begin
      d_in[0] = DIFF_W'(in_word.bx)       - DIFF_W'(in_word.ax);
      d_in[1] = DIFF_W'(in_word.by_coord) - DIFF_W'(in_word.ay);
      d_in[2] = DIFF_W'(in_word.bz)       - DIFF_W'(in_word.az);
      d_in[3] = DIFF_W'(in_word.cx)       - DIFF_W'(in_word.bx);
      d_in[4] = DIFF_W'(in_word.cy)       - DIFF_W'(in_word.by_coord);
      d_in[5] = DIFF_W'(in_word.cz)       - DIFF_W'(in_word.bz);
   end

   always_comb begin
      p_in[0] = PROD_W'(d_ff[1]) * PROD_W'(d_ff[5]);
      p_in[1] = PROD_W'(d_ff[2]) * PROD_W'(d_ff[4]);
      p_in[2] = PROD_W'(d_ff[2]) * PROD_W'(d_ff[3]);
      p_in[3] = PROD_W'(d_ff[0]) * PROD_W'(d_ff[5]);
      p_in[4] = PROD_W'(d_ff[0]) * PROD_W'(d_ff[4]);
      p_in[5] = PROD_W'(d_ff[1]) * PROD_W'(d_ff[3]);
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         c_in[j] = CROSS_W'(p_ff[2*j]) - CROSS_W'(p_ff[2*j+1]);
      end
   end

   always_comb begin
      logic [CROSS_W-1:0] a;
      for (int j = 0; j < 3; j++) begin
         neg_in[j] = c_ff[j][CROSS_W-1];
         a = neg_in[j] ? (CROSS_W'(0) - c_ff[j]) : c_ff[j];
         mag_in[j] = a[MAG_W-1:0];
         if (mag_in[j] < MAG_W'(zero_threshold)) begin
            mag_in[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff     <= d_in;
         p_ff     <= p_in;
         c_ff     <= c_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         last_ff  <= {last_ff[1:0], in_word.last_triangle};
         last4_ff <= last_ff[2];
      end
   end

   assign out_valid      = vld_ff[3];
   assign out_mag        = mag_ff;
   assign out_side.neg   = neg_ff;
   assign out_side.degen = 1'b0;
   assign out_side.last  = last4_ff;

endmodule

@@ design/tfn_norm.sv @@
// tfn_norm: common power-of-two scaling, squares and sum of squares.
// Four register stages; depends on tfn_pkg.
module tfn_norm
   import tfn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  mag_vec_type       in_mag,
   input  side_type          in_side,
   output logic              out_valid,
   output sm_vec_type        out_sm,
   output logic [SUM_W-1:0]  out_sum,
   output side_type          out_side
);

   logic [3:0]            vld_ff;
   side_type              side_ff [4];
   side_type              side5_in;
   mag_vec_type           m5_ff;
   logic                  up_in;
   logic                  up_ff;
   logic [SH_W-1:0]       amt_in;
   logic [SH_W-1:0]       amt_ff;
   sm_vec_type            sm_in;
   sm_vec_type            sm6_ff;
   sm_vec_type            sm7_ff;
   sm_vec_type            sm8_ff;
   logic [SQ_W-1:0]       sq_in [3];
   logic [SQ_W-1:0]       sq_ff [3];
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W-1:0]      sum_ff;

   always_comb begin
      logic [MAG_W-1:0] mx;
      logic [TB_W-1:0]  tb;
      logic [TB_W-1:0]  diff;
      mx = in_mag[0];
      if (in_mag[1] > mx) begin
         mx = in_mag[1];
      end
      if (in_mag[2] > mx) begin
         mx = in_mag[2];
      end
      tb = top_bit(mx);
      up_in = tb <= TB_W'(NORM_TOP);
      diff = up_in ? (TB_W'(NORM_TOP) - tb) : (tb - TB_W'(NORM_TOP));
      amt_in = diff[SH_W-1:0];
      side5_in = in_side;
      side5_in.degen = mx == '0;
   end

   always_comb begin
      logic [MAG_W-1:0] s;
      for (int j = 0; j < 3; j++) begin
         s = up_ff ? (m5_ff[j] << amt_ff) : (m5_ff[j] >> amt_ff);
         sm_in[j] = s[SM_W-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq_in[j] = SQ_W'(sm6_ff[j]) * SQ_W'(sm6_ff[j]);
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side5_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         m5_ff      <= in_mag;
         up_ff      <= up_in;
         amt_ff     <= amt_in;
         sm6_ff     <= sm_in;
         sq_ff      <= sq_in;
         sm7_ff     <= sm6_ff;
         sum_ff     <= sum_in;
         sm8_ff     <= sm7_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_sm    = sm8_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side_ff[3];

endmodule

@@ design/tfn_sqrt.sv @@
// tfn_sqrt: pipelined integer square root, one root bit per register stage.
// ROOT_W stages; depends on tfn_pkg.
module tfn_sqrt
   import tfn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [SUM_W-1:0]   in_sum,
   input  sm_vec_type         in_sm,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output sm_vec_type         out_sm,
   output side_type           out_side
);

   logic                vld_ff  [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SUM_W-1:0]    rad_ff  [ROOT_W];
   sm_vec_type          sm_ff   [ROOT_W];
   side_type            side_ff [ROOT_W];

   logic                pv_vld  [ROOT_W];
   logic [REM_W-1:0]    pv_rem  [ROOT_W];
   logic [ROOT_W-1:0]   pv_root [ROOT_W];
   logic [SUM_W-1:0]    pv_rad  [ROOT_W];
   sm_vec_type          pv_sm   [ROOT_W];
   side_type            pv_side [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign pv_vld[k]  = in_valid;
         assign pv_rem[k]  = '0;
         assign pv_root[k] = '0;
         assign pv_rad[k]  = in_sum;
         assign pv_sm[k]   = in_sm;
         assign pv_side[k] = in_side;
      end else begin : g_next
         assign pv_vld[k]  = vld_ff[k-1];
         assign pv_rem[k]  = rem_ff[k-1];
         assign pv_root[k] = root_ff[k-1];
         assign pv_rad[k]  = rad_ff[k-1];
         assign pv_sm[k]   = sm_ff[k-1];
         assign pv_side[k] = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {pv_rem[k][REM_W-3:0], pv_rad[k][SUM_W-1:SUM_W-2]};
         trial  = REM_W'({pv_root[k], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {pv_root[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {pv_root[k][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= pv_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= pv_rad[k] << 2;
            sm_ff[k]   <= pv_sm[k];
            side_ff[k] <= pv_side[k];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_sm    = sm_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

@@ design/tfn_div.sv @@
// tfn_div: rounded divide of each scaled component by the length, three lanes.
// One setup stage and Q_W restoring stages; depends on tfn_pkg.
module tfn_div
   import tfn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  in_root,
   input  sm_vec_type         in_sm,
   input  side_type           in_side,
   output logic               out_valid,
   output q_vec_type          out_q,
   output side_type           out_side
);

   logic                       vld_ff  [Q_W+1];
   logic [2:0][DREM_W-1:0]     rem_ff  [Q_W+1];
   logic [2:0][Q_W-1:0]        lo_ff   [Q_W+1];
   q_vec_type                  q_ff    [Q_W+1];
   logic [ROOT_W-1:0]          len_ff  [Q_W+1];
   side_type                   side_ff [Q_W+1];

   logic [2:0][DREM_W-1:0]     rem0_in;
   logic [2:0][Q_W-1:0]        lo0_in;

   always_comb begin
      logic [NUM_W-1:0] num;
      for (int j = 0; j < 3; j++) begin
         num = (NUM_W'(in_sm[j]) << ONE_SHIFT) + NUM_W'(in_root >> 1);
         rem0_in[j] = DREM_W'(num[NUM_W-1:Q_W]);
         lo0_in[j]  = num[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem0_in;
         lo_ff[0]   <= lo0_in;
         q_ff[0]    <= '0;
         len_ff[0]  <= in_root;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      logic [2:0][DREM_W-1:0] rem_in;
      q_vec_type              q_in;

      always_comb begin
         logic [DREM_W-1:0] rem2;
         for (int j = 0; j < 3; j++) begin
            rem2 = {rem_ff[k-1][j][DREM_W-2:0], lo_ff[k-1][j][Q_W-1]};
            if (rem2 >= DREM_W'(len_ff[k-1])) begin
               rem_in[j] = rem2 - DREM_W'(len_ff[k-1]);
               q_in[j]   = {q_ff[k-1][j][Q_W-2:0], 1'b1};
            end else begin
               rem_in[j] = rem2;
               q_in[j]   = {q_ff[k-1][j][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            lo_ff[k]   <= {lo_ff[k-1][2][Q_W-2:0], 1'b0,
                           lo_ff[k-1][1][Q_W-2:0], 1'b0,
                           lo_ff[k-1][0][Q_W-2:0], 1'b0};
            q_ff[k]    <= q_in;
            len_ff[k]  <= len_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_q     = q_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

@@ design/triangle_face_normal.sv @@
// triangle_face_normal: top level, unit face normal of one triangle per word.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_sqrt, tfn_div.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_word (three vertices, last)
//   rsp      out        rsp_valid/stall    rsp_word (normal, degenerate, last)
//   csr      in/out     APB write/read     zero_threshold at byte 0
//
// One word enters per cycle while req_stall is low; a result passes 4 cross, 4 scale,
// 31 square root, 16 divide and 1 output stage. The 31 root stages are the longest part.
// The whole pipe holds while rsp_word waits under rsp_stall; nothing is lost.
// Reset clears every valid bit and sets zero_threshold to 1.
module triangle_face_normal
   import tfn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic               adv;
   logic [THR_W-1:0]   thr_ff;
   logic               thr_hit;

   logic               cr_valid;
   mag_vec_type        cr_mag;
   side_type           cr_side;
   logic               nm_valid;
   sm_vec_type         nm_sm;
   logic [SUM_W-1:0]   nm_sum;
   side_type           nm_side;
   logic               sq_valid;
   logic [ROOT_W-1:0]  sq_root;
   sm_vec_type         sq_sm;
   side_type           sq_side;
   logic               dv_valid;
   q_vec_type          dv_q;
   side_type           dv_side;

   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       rsp_word_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign thr_hit    = csr_paddr[2] == CSR_ZERO_THRESHOLD;
   assign csr_pready = 1'b1;
   assign csr_prdata = thr_hit ? CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ZERO_THRESHOLD_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && thr_hit) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   tfn_cross u_cross (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_valid),
      .in_word        (req_word),
      .zero_threshold (thr_ff),
      .out_valid      (cr_valid),
      .out_mag        (cr_mag),
      .out_side       (cr_side)
   );

   tfn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cr_valid),
      .in_mag    (cr_mag),
      .in_side   (cr_side),
      .out_valid (nm_valid),
      .out_sm    (nm_sm),
      .out_sum   (nm_sum),
      .out_side  (nm_side)
   );

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nm_valid),
      .in_sum    (nm_sum),
      .in_sm     (nm_sm),
      .in_side   (nm_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_sm    (sq_sm),
      .out_side  (sq_side)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_sm     (sq_sm),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   always_comb begin
      logic [Q_W-1:0]   q;
      logic [OUT_W-1:0] n [3];
      for (int j = 0; j < 3; j++) begin
         q = (dv_q[j] > ONE_Q14) ? ONE_Q14 : dv_q[j];
         n[j] = dv_side.neg[j] ? (OUT_W'(0) - OUT_W'(q)) : OUT_W'(q);
         if (dv_side.degen) begin
            n[j] = '0;
         end
      end
      rsp_word_in.normal_x   = n[0];
      rsp_word_in.normal_y   = n[1];
      rsp_word_in.normal_z   = n[2];
      rsp_word_in.degenerate = dv_side.degen;
      rsp_word_in.last       = dv_side.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ design/tfn_checker.sv @@
// tfn_checker: port-level assertions for triangle_face_normal, bound to the top.
// Depends on tfn_pkg and triangle_face_normal.
module tfn_checker
   import tfn_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_word_type           req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_word_type           rsp_word,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic [CSR_ADDR_W-1:0]  csr_paddr,
   input logic [CSR_DATA_W-1:0]  csr_pwdata,
   input logic [CSR_DATA_W-1:0]  csr_prdata,
   input logic                   csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.degenerate |->
         rsp_word.normal_x == '0 && rsp_word.normal_y == '0 && rsp_word.normal_z == '0)
      else $error("degenerate word carries a nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_word.normal_x <= 16'sd16384 && rsp_word.normal_x >= -16'sd16384 &&
         rsp_word.normal_y <= 16'sd16384 && rsp_word.normal_y >= -16'sd16384 &&
         rsp_word.normal_z <= 16'sd16384 && rsp_word.normal_z >= -16'sd16384)
      else $error("normal component outside unit range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

@@ test/triangle_face_normal_tb.sv @@
// triangle_face_normal_tb: checks the face normal pipeline word by word against a
// built-in fixed point predictor, with random idling on both channels but in the last phase.
// Depends on tfn_pkg and triangle_face_normal.
module triangle_face_normal_tb;
   import tfn_pkg::*;

   localparam int LATENCY   = 56;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      req_word_type word;
      logic         known;
      rsp_word_type result;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rsp_word_type expected_normals[$];
   logic [15:0]  threshold;
   int           mismatches = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;
   bit           timed_out = 1'b0;

   triangle_face_normal uut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE && !timed_out) begin
         timed_out = 1'b1;
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > s) bit_v >>= 2;
      while (bit_v != 0) begin
         if (s >= res + bit_v) begin
            s = s - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_word_type face_normal(input req_word_type w, input logic [15:0] thr);
      longint      d1x, d1y, d1z, d2x, d2y, d2z;
      longint      cr[3];
      logic [63:0] m[3];
      logic [63:0] mx, sum, len, q, p;
      int          tb;
      rsp_word_type r;
      d1x = longint'(w.bx) - longint'(w.ax);
      d1y = longint'(w.by_coord) - longint'(w.ay);
      d1z = longint'(w.bz) - longint'(w.az);
      d2x = longint'(w.cx) - longint'(w.bx);
      d2y = longint'(w.cy) - longint'(w.by_coord);
      d2z = longint'(w.cz) - longint'(w.bz);
      cr[0] = d1y * d2z - d1z * d2y;
      cr[1] = d1z * d2x - d1x * d2z;
      cr[2] = d1x * d2y - d1y * d2x;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
         if (m[i] < 64'(thr)) m[i] = 0;
         if (m[i] > mx) mx = m[i];
      end
      r = '0;
      r.last = w.last_triangle;
      if (mx == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      tb = -1;
      p = mx;
      while (p != 0) begin
         tb++;
         p >>= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (tb > NORM_TOP) m[i] = m[i] >> (tb - NORM_TOP);
         else m[i] = m[i] << (NORM_TOP - tb);
         sum += m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd16384 + (len >> 1)) / len;
         if (q > 64'd16384) q = 64'd16384;
         if (cr[i] < 0) q = -q;
         if (i == 0) r.normal_x = q[15:0];
         else if (i == 1) r.normal_y = q[15:0];
         else r.normal_z = q[15:0];
      end
      return r;
   endfunction

   task automatic write_threshold(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(CSR_ZERO_THRESHOLD) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      threshold = value[15:0];
   endtask

   task automatic send_triangle(input req_word_type w, input logic known,
                                input rsp_word_type result);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      expected_normals.push_back(known ? result : face_normal(w, threshold));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic req_word_type random_triangle(input int mode);
      req_word_type w;
      coord_type    base;
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(req_word_type)-1:0];
      if (mode == 1) begin
         base = coord_type'($urandom);
         w.ax = base + coord_type'($urandom_range(0, 15));
         w.bx = base + coord_type'($urandom_range(0, 15));
         w.cx = base + coord_type'($urandom_range(0, 15));
         w.ay = coord_type'(int'($urandom_range(0, 31)) - 16);
         w.by_coord = coord_type'(int'($urandom_range(0, 31)) - 16);
         w.cy = coord_type'(int'($urandom_range(0, 31)) - 16);
         w.az = coord_type'($urandom_range(0, 7));
         w.bz = w.az;
         w.cz = coord_type'($urandom_range(0, 7));
      end else if (mode == 2) begin
         w.bx = w.ax;
         w.by_coord = w.ay;
         w.bz = w.az;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_word);
         end else begin
            if (rsp_word !== expected_normals[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%0d y=%0d z=%0d dg=%b l=%b,",
                     expected_normals[0].normal_x, expected_normals[0].normal_y,
                     expected_normals[0].normal_z, expected_normals[0].degenerate,
                     expected_normals[0].last,
                     " got x=%0d y=%0d z=%0d dg=%b l=%b",
                     rsp_word.normal_x, rsp_word.normal_y,
                     rsp_word.normal_z, rsp_word.degenerate, rsp_word.last);
            end
            void'(expected_normals.pop_front());
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic [15:0]  thr_list[4];
      threshold = ZERO_THRESHOLD_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      row.known = 1'b1;
      row.result = '0;
      row.result.degenerate = 1'b1;
      row.word = '0;
      rows.push_back(row);
      row.word = '1;
      row.result.last = 1'b1;
      rows.push_back(row);
      row.known = 1'b0;
      row.word = '0;
      row.word.bx = 16'sh0100;
      row.word.cy = 16'sh0100;
      row.word.by_coord = '0;
      row.word.cx = 16'sh0100;
      rows.push_back(row);
      row.word = '0;
      row.word.ax = 16'sh8000;
      row.word.bx = 16'sh7fff;
      row.word.by_coord = 16'sh8000;
      row.word.cy = 16'sh7fff;
      row.word.cz = 16'sh7fff;
      rows.push_back(row);
      row.word = '0;
      row.word.ay = 16'sh7fff;
      row.word.bz = 16'sh8000;
      row.word.cx = 16'sh7fff;
      row.word.last_triangle = 1'b1;
      rows.push_back(row);
      row.word = '0;
      row.word.bx = 16'sh0001;
      row.word.cx = 16'sh0001;
      row.word.cy = 16'sh0001;
      rows.push_back(row);
      row.word = '0;
      row.word.bx = 16'sh0003;
      row.word.cx = 16'sh0006;
      rows.push_back(row);
      for (int i = 0; i < 6; i++) begin
         row.word = random_triangle(i % 3);
         rows.push_back(row);
      end
      foreach (rows[i]) send_triangle(rows[i].word, rows[i].known, rows[i].result);
      drain();

      thr_list[0] = 16'h0000;
      thr_list[1] = 16'hffff;
      thr_list[2] = 16'h0100;
      thr_list[3] = 16'h0001;
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold({16'($urandom_range(0, 65535)), thr_list[ph]});
         if (ph == 3) quiet = 1'b1;
         for (int n = 0; n < 125; n++) begin
            send_triangle(random_triangle($urandom_range(0, 2)), 1'b0, '0);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
